// ===== sv/slrg_pkg.sv =====
// Shared constants for the shuffled Lehmer generator.
package slrg_pkg;

	localparam int TABLE_DEPTH_DEF   = 32;
	localparam int EXTRA_WARMUP_DEF  = 8;
	localparam int FRACTION_BITS_DEF = 24;

	localparam int VALUE_W = 31;
	localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam int LCG_MUL = 16807;

	// Shared multiplier operand widths: unsigned 31-bit value, signed 17-bit span
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

endpackage

// ===== sv/slrg_ram.sv =====
// Generic simple dual-port RAM with registered read.
module slrg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/slrg_mul.sv =====
// Shared signed multiplier with registered product.
module slrg_mul (
	input  logic                               clk,
	input  logic signed [slrg_pkg::MUL_A_W-1:0] a,
	input  logic signed [slrg_pkg::MUL_B_W-1:0] b,
	output logic signed [slrg_pkg::PROD_W-1:0]  p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== sv/shuffled_lehmer_random_generator_unit.sv =====
// Top level: sequencer of the shuffled Lehmer generator around one multiplier.
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  seed_value
// in       in         in_valid / in_ready    op, range_low, range_high
// out      out        out_valid / out_ready  draw_valid, raw_value, fraction, scaled_value
//
// A reseed item goes straight from idle to the done state, then to the result register.
// A draw runs the slot compare, two multiplier passes (Lehmer step, range scaling)
// and the table read. The first draw after reset or reseed adds a warm-up of
// TABLE_DEPTH + EXTRA_WARMUP Lehmer steps through the shared multiplier. Reset clears
// control state, the seed and the generator registers but not the table; table entries
// are always written before they are read.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register, and the sequencer holds in its last step while it is full and not taken.
module shuffled_lehmer_random_generator_unit #(
	parameter int TABLE_DEPTH   = slrg_pkg::TABLE_DEPTH_DEF,
	parameter int EXTRA_WARMUP  = slrg_pkg::EXTRA_WARMUP_DEF,
	parameter int FRACTION_BITS = slrg_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [30:0]              seed_value,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic signed [15:0]       range_low,
	input  logic signed [15:0]       range_high,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     draw_valid,
	output logic [30:0]              raw_value,
	output logic [FRACTION_BITS-1:0] fraction,
	output logic signed [15:0]       scaled_value
);

	localparam int VW     = slrg_pkg::VALUE_W;
	localparam int PW     = slrg_pkg::PROD_W;
	localparam int F      = FRACTION_BITS;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int STEPS  = TABLE_DEPTH + EXTRA_WARMUP;
	localparam int CNT_W  = $clog2(STEPS);
	localparam int SLOT_DIV_I = 1 + 2147483646 / TABLE_DEPTH;
	localparam longint ONE     = longint'(1) << F;
	localparam longint LIMIT_L = ONE - (12 * ONE + 99999999) / 100000000;
	localparam logic [F-1:0] LIMIT = F'(LIMIT_L);
	localparam logic [PW-1:0] ROUND_BIAS = PW'(ONE - 1);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_INIT_MUL  = 4'd1;
	localparam logic [3:0] S_INIT_FOLD = 4'd2;
	localparam logic [3:0] S_GEN_MUL   = 4'd4;
	localparam logic [3:0] S_GEN_FOLD  = 4'd5;
	localparam logic [3:0] S_READ      = 4'd6;
	localparam logic [3:0] S_SC_MUL    = 4'd7;
	localparam logic [3:0] S_SC_ADD    = 4'd8;
	localparam logic [3:0] S_SC_SHIFT  = 4'd9;
	localparam logic [3:0] S_DONE      = 4'd10;

	logic [3:0]             state_q;
	logic                   needs_init_q;
	logic [VW-1:0]          seed_q;
	logic [VW-1:0]          gen_q;
	logic [VW-1:0]          shout_q;
	logic [IDX_W-1:0]       slot_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [F-1:0]           frac_q;
	logic signed [15:0]     lo_q;
	logic signed [15:0]     hi_q;
	logic                   pend_draw_q;
	logic signed [PW-1:0]   total_q;
	logic signed [15:0]     scaled_q;
	logic                   out_valid_q;

	logic signed [slrg_pkg::MUL_A_W-1:0] mul_a;
	logic signed [slrg_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]                mul_p;

	logic [16:0]      span;
	logic [31:0]      fold_sum;
	logic [VW-1:0]    fold_val;
	logic [VW-1:0]    seed_fix;
	logic [(1 << IDX_W)-1:0] slot_ge;
	logic [IDX_W-1:0] slot_sel;
	logic [IDX_W-1:0] slot_use;
	logic [VW-1:0]    ram_rdata;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [VW-1:0]    ram_wdata;
	logic [VW+F-1:0]  fr_wide;
	logic [31:0]      fr_sum;
	logic [F-1:0]     fr_q;
	logic [F-1:0]     fr_clamp;
	logic signed [PW-1:0] lo_shift;
	logic signed [PW-1:0] total_d;
	logic signed [PW-1:0] biased;
	logic signed [PW-1:0] shifted;
	logic             out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Shared multiplier: Lehmer step during warm-up and draw, range scaling afterwards
	always_comb begin
		span = {hi_q[15], hi_q} - {lo_q[15], lo_q};
		if (state_q == S_SC_MUL) begin
			mul_a = slrg_pkg::MUL_A_W'(frac_q);
			mul_b = {span[16], span};
		end else begin
			mul_a = {1'b0, gen_q};
			mul_b = slrg_pkg::MUL_B_W'(slrg_pkg::LCG_MUL);
		end
	end

	slrg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Reduce x * 16807 modulo 2^31-1 by folding the bits above bit 30
	always_comb begin
		fold_sum = {17'd0, mul_p[45:31]} + {1'b0, mul_p[30:0]};
		if (fold_sum >= {1'b0, slrg_pkg::LCG_MOD}) begin
			fold_sum = fold_sum - {1'b0, slrg_pkg::LCG_MOD};
		end
		fold_val = fold_sum[VW-1:0];
	end

	always_comb begin
		seed_fix = seed_q;
		if (seed_q == '0 || seed_q == slrg_pkg::LCG_MOD) begin
			seed_fix = VW'(1);
		end
	end

	// Table slot: compare against every k * SLOT_DIV at once, then search the
	// resulting thermometer code bit by bit
	always_comb begin
		slot_ge = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			slot_ge[k] = {2'b00, shout_q} >= 33'(longint'(k) * SLOT_DIV_I);
		end
		slot_sel = '0;
		for (int b = IDX_W - 1; b >= 0; b--) begin
			if (slot_ge[slot_sel | IDX_W'(1 << b)]) begin
				slot_sel = slot_sel | IDX_W'(1 << b);
			end
		end
		slot_use = (slot_q > IDX_W'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1) : slot_q;
	end

	// raw * 2^F / (2^31-1): high part plus one when the folded sum reaches the modulus
	always_comb begin
		fr_wide = {ram_rdata, {F{1'b0}}};
		fr_sum  = 32'(fr_wide[VW+F-1:VW]) + {1'b0, fr_wide[VW-1:0]};
		fr_q    = fr_wide[VW+F-1:VW] + F'(fr_sum >= {1'b0, slrg_pkg::LCG_MOD});
		fr_clamp = (fr_q > LIMIT) ? LIMIT : fr_q;
	end

	always_comb begin
		lo_shift = {{(PW-16){lo_q[15]}}, lo_q} <<< F;
		total_d  = mul_p + lo_shift;
		// Truncate toward zero: bias negative totals before the arithmetic shift
		biased   = total_q + (total_q[PW-1] ? $signed(ROUND_BIAS) : $signed(PW'(0)));
		shifted  = biased >>> F;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_use;
		ram_wdata = gen_q;
		if (state_q == S_INIT_FOLD) begin
			ram_we    = (cnt_q < CNT_W'(TABLE_DEPTH));
			ram_waddr = cnt_q[IDX_W-1:0];
			ram_wdata = fold_val;
		end else if (state_q == S_READ) begin
			ram_we = 1'b1;
		end
	end

	slrg_ram #(
		.WIDTH (VW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == S_GEN_FOLD),
		.raddr (slot_use),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			needs_init_q <= 1'b1;
			seed_q       <= VW'(1);
			gen_q        <= '0;
			shout_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= seed_value;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pend_draw_q <= !op;
						lo_q        <= range_low;
						hi_q        <= range_high;
						if (op) begin
							needs_init_q <= 1'b1;
							state_q      <= S_DONE;
						end else if (needs_init_q) begin
							gen_q   <= seed_fix;
							cnt_q   <= CNT_W'(STEPS - 1);
							state_q <= S_INIT_MUL;
						end else begin
							state_q <= S_GEN_MUL;
						end
					end
				end
				S_INIT_MUL: begin
					state_q <= S_INIT_FOLD;
				end
				S_INIT_FOLD: begin
					gen_q <= fold_val;
					if (cnt_q == '0) begin
						// Slot 0 holds the last warm-up value, which is also the output
						shout_q      <= fold_val;
						needs_init_q <= 1'b0;
						state_q      <= S_GEN_MUL;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_INIT_MUL;
					end
				end
				S_GEN_MUL: begin
					slot_q  <= slot_sel;
					state_q <= S_GEN_FOLD;
				end
				S_GEN_FOLD: begin
					gen_q   <= fold_val;
					state_q <= S_READ;
				end
				S_READ: begin
					shout_q <= ram_rdata;
					frac_q  <= fr_clamp;
					state_q <= S_SC_MUL;
				end
				S_SC_MUL: begin
					state_q <= S_SC_ADD;
				end
				S_SC_ADD: begin
					total_q <= total_d;
					state_q <= S_SC_SHIFT;
				end
				S_SC_SHIFT: begin
					scaled_q <= shifted[15:0];
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register; a reseed acknowledgement carries zeros
	always_ff @(posedge clk) begin
		if (out_load) begin
			draw_valid   <= pend_draw_q;
			raw_value    <= pend_draw_q ? shout_q : '0;
			fraction     <= pend_draw_q ? frac_q : '0;
			scaled_value <= pend_draw_q ? scaled_q : '0;
		end
	end

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer stayed idle after an input transfer");

	a_reseed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw_valid |-> raw_value == '0 && fraction == '0 && scaled_value == '0)
		else $error("reseed acknowledgement carries nonzero payload");

	a_draw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && draw_valid |-> raw_value != '0 && raw_value != slrg_pkg::LCG_MOD
			&& fraction <= LIMIT)
		else $error("draw result out of range");

	a_init_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GEN_MUL |-> !needs_init_q)
		else $error("draw started before table warm-up finished");

endmodule

// ===== bench/tb_shuffled_lehmer_random_generator_unit.sv =====
// Self-checking bench for the shuffled Lehmer generator: random handshakes, predicted draws.
`timescale 1ns / 1ps

module tb_shuffled_lehmer_random_generator_unit;

	localparam int DEPTH   = slrg_pkg::TABLE_DEPTH_DEF;
	localparam int WARMUP  = slrg_pkg::EXTRA_WARMUP_DEF;
	localparam int FRAC_W  = slrg_pkg::FRACTION_BITS_DEF;

	localparam longint MODULUS    = longint'(slrg_pkg::LCG_MOD);
	localparam longint MULTIPLIER = longint'(slrg_pkg::LCG_MUL);
	localparam longint SCHRAGE_Q  = 127773;
	localparam longint SCHRAGE_R  = 2836;
	localparam longint SLOT_DIV   = 1 + (MODULUS - 1) / DEPTH;
	localparam longint FRAC_ONE   = longint'(1) << FRAC_W;
	localparam longint FRAC_LIMIT = FRAC_ONE - (12 * FRAC_ONE + 99999999) / 100000000;

	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	localparam logic [30:0] SEED_ZERO = 31'h0000_0000;
	localparam logic [30:0] SEED_ONE  = 31'h0000_0001;
	localparam logic [30:0] SEED_TOP  = 31'h7FFF_FFFE;
	localparam logic [30:0] SEED_MOD  = 31'h7FFF_FFFF;

	localparam int STALL_LIMIT   = 4000;
	localparam int TAIL_CYCLES   = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 210;
	localparam int PRINT_CAP     = 40;

	typedef struct {
		logic               op;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
	} rng_request_t;

	typedef struct {
		logic               draw_valid;
		logic [30:0]        raw;
		logic [FRAC_W-1:0]  frac;
		logic signed [15:0] scaled;
	} rng_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [30:0]              seed_value = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     op = 1'b0;
	logic signed [15:0]       range_low = '0;
	logic signed [15:0]       range_high = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     draw_valid;
	logic [30:0]              raw_value;
	logic [FRAC_W-1:0]        fraction;
	logic signed [15:0]       scaled_value;

	// generator state as the block should hold it
	logic [30:0] seed_reg = SEED_ONE;
	logic [30:0] lehmer_state = '0;
	logic [30:0] shuffle_out = '0;
	logic        init_pending = 1'b1;
	logic [30:0] shuffle_slots [DEPTH];

	rng_request_t pending_requests [$];
	rng_result_t  expected_draws [$];
	rng_request_t cur_req;

	int  outstanding = 0;
	int  errors = 0;
	int  stall_cycles = 0;
	int  send_wait = 0;
	int  hold_cycles = 0;
	bit  send_busy = 1'b0;
	bit  accept_busy = 1'b0;

	shuffled_lehmer_random_generator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.seed_value  (seed_value),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.range_low   (range_low),
		.range_high  (range_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.draw_valid  (draw_valid),
		.raw_value   (raw_value),
		.fraction    (fraction),
		.scaled_value(scaled_value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// One minimal-standard step, Schrage's method keeps every product below 2^31.
	function automatic logic [30:0] lehmer_step(input logic [30:0] x);
		longint v;
		longint k;
		v = longint'(x) % MODULUS;
		k = v / SCHRAGE_Q;
		v = MULTIPLIER * (v - k * SCHRAGE_Q) - SCHRAGE_R * k;
		if (v < 0)
			v += MODULUS;
		return v[30:0];
	endfunction

	task automatic fill_shuffle_slots();
		logic [30:0] x;
		x = seed_reg;
		if (x == SEED_ZERO || x == SEED_MOD)
			x = SEED_ONE;
		for (int j = DEPTH + WARMUP - 1; j >= 0; j--) begin
			x = lehmer_step(x);
			if (j < DEPTH)
				shuffle_slots[j] = x;
		end
		lehmer_state = x;
		shuffle_out = shuffle_slots[0];
		init_pending = 1'b0;
	endtask

	task automatic predict_draw(input rng_request_t req);
		rng_result_t res;
		longint slot;
		longint frac;
		longint total;
		longint scaled;
		if (req.op == OP_RESEED) begin
			init_pending = 1'b1;
			res.draw_valid = 1'b0;
			res.raw = '0;
			res.frac = '0;
			res.scaled = '0;
		end else begin
			if (init_pending)
				fill_shuffle_slots();
			lehmer_state = lehmer_step(lehmer_state);
			slot = longint'(shuffle_out) / SLOT_DIV;
			if (slot >= DEPTH)
				slot = DEPTH - 1;
			shuffle_out = shuffle_slots[slot];
			shuffle_slots[slot] = lehmer_state;
			frac = (longint'(shuffle_out) << FRAC_W) / MODULUS;
			if (frac > FRAC_LIMIT)
				frac = FRAC_LIMIT;
			total = longint'(req.lo) * FRAC_ONE + frac * (longint'(req.hi) - longint'(req.lo));
			scaled = total / FRAC_ONE;
			res.draw_valid = 1'b1;
			res.raw = shuffle_out;
			res.frac = frac[FRAC_W-1:0];
			res.scaled = scaled[15:0];
		end
		expected_draws.push_back(res);
	endtask

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic int pick_gap(input bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_draw(cur_req);
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					op <= cur_req.op;
					range_low <= cur_req.lo;
					range_high <= cur_req.hi;
					send_wait = pick_gap(send_busy);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		rng_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				outstanding--;
				if (expected_draws.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, raw %0d", raw_value));
				end else begin
					want = expected_draws.pop_front();
					if (draw_valid !== want.draw_valid)
						report_mismatch($sformatf("draw_valid got %0b expected %0b",
							draw_valid, want.draw_valid));
					if (raw_value !== want.raw)
						report_mismatch($sformatf("raw_value got %0d expected %0d",
							raw_value, want.raw));
					if (fraction !== want.frac)
						report_mismatch($sformatf("fraction got %0d expected %0d",
							fraction, want.frac));
					if (scaled_value !== want.scaled)
						report_mismatch($sformatf("scaled_value got %0d expected %0d",
							scaled_value, want.scaled));
				end
			end
			if (hold_cycles == 0 && accept_busy && $urandom_range(0, 3) == 0)
				hold_cycles = pick_gap(1'b1);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic queue_request(input logic o, input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		rng_request_t req;
		req.op = o;
		req.lo = lo;
		req.hi = hi;
		outstanding++;
		pending_requests.push_back(req);
	endtask

	task automatic queue_random_request();
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		lo = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: hi = 16'($urandom);
			5, 6, 7: hi = lo + 16'($urandom_range(0, 15));
			8: hi = lo;
			default: begin
				lo = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
				hi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
			end
		endcase
		queue_request(($urandom_range(0, 99) < 4) ? OP_RESEED : OP_DRAW, lo, hi);
	endtask

	// hold the sender until every queued request has its result back
	task automatic wait_all_done();
		while (outstanding > 0)
			@(posedge clk);
	endtask

	task automatic write_seed(input logic [30:0] s);
		@(posedge clk);
		cfg_valid <= 1'b1;
		seed_value <= s;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		seed_reg = s;
	endtask

	initial begin
		logic [30:0] s;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset seed, range extremes, reversed and empty ranges
		queue_request(OP_DRAW, 16'sh8000, 16'sh7FFF);
		queue_request(OP_DRAW, 16'sh7FFF, 16'sh8000);
		queue_request(OP_DRAW, 16'sh0000, 16'sh0000);
		queue_request(OP_DRAW, 16'sh8000, 16'sh8000);
		queue_request(OP_DRAW, 16'sh7FFF, 16'sh7FFF);
		queue_request(OP_DRAW, -16'sd1, 16'sh0000);
		queue_request(OP_DRAW, 16'sh0000, 16'sh0001);
		queue_request(OP_RESEED, -16'sd1, -16'sd1);
		queue_request(OP_DRAW, -16'sd100, 16'sd100);
		wait_all_done();

		// degenerate seeds fall back to one
		write_seed(SEED_ZERO);
		queue_request(OP_RESEED, 16'sh0000, 16'sh0000);
		queue_request(OP_DRAW, 16'sh8000, 16'sh7FFF);
		queue_request(OP_DRAW, 16'sd10, -16'sd10);
		wait_all_done();
		write_seed(SEED_MOD);
		queue_request(OP_RESEED, 16'sh7FFF, 16'sh8000);
		queue_request(OP_DRAW, 16'sh8000, 16'sh7FFF);
		queue_request(OP_DRAW, 16'sh0000, 16'sh0100);
		wait_all_done();

		// new seed only takes effect at the next reinitialization
		write_seed(SEED_TOP);
		queue_request(OP_DRAW, 16'sh8000, 16'sh7FFF);
		queue_request(OP_RESEED, 16'sh0000, 16'sh0000);
		queue_request(OP_DRAW, 16'sh8000, 16'sh7FFF);
		queue_request(OP_DRAW, 16'sh7FFF, 16'sh8000);
		queue_request(OP_RESEED, 16'sh0000, 16'sh0000);
		queue_request(OP_RESEED, 16'sh0000, 16'sh0000);
		queue_request(OP_DRAW, 16'sh0000, 16'sh7FFF);
		wait_all_done();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: s = SEED_ZERO;
				1: s = SEED_ONE;
				2: s = SEED_TOP;
				3: s = SEED_MOD;
				default: s = 31'($urandom);
			endcase
			write_seed(s);
			send_busy = (p % 4 != 1);
			accept_busy = (p % 4 != 2);
			if ($urandom_range(0, 1))
				queue_request(OP_RESEED, 16'($urandom), 16'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_random_request();
			wait_all_done();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_draws.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_draws.size()));
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
sv/slrg_pkg.sv
sv/slrg_ram.sv
sv/slrg_mul.sv
sv/shuffled_lehmer_random_generator_unit.sv
bench/tb_shuffled_lehmer_random_generator_unit.sv
